[src/bvd_pkg.sv]
//------------------------------------------------------------------------------
// bvd_pkg: shared types and constants
// Register indexes, input kinds, the tap passed from cell to cell and the
// result entry held in the output buffer.
//------------------------------------------------------------------------------
`default_nettype none

package bvd_pkg;

	localparam int Z_MAX = 1024;
	localparam int ZW    = 11;
	localparam int ZCW   = 10;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	localparam logic FUNC_VOXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef struct packed {
		logic live;
		logic occ;
	} bvd_tap_t;

	typedef struct packed {
		logic dilated;
		logic last;
	} bvd_result_t;

endpackage

`default_nettype wire

[src/bvd_axis_cell.sv]
//------------------------------------------------------------------------------
// bvd_axis_cell: one-axis dilation cell
// Delays its stream by dly requests in a ring buffer holding two taps, and ORs
// the center with its neighbors one stride before and after, clipped by the
// center's coordinate along the axis. dly of zero passes the stream through.
//------------------------------------------------------------------------------
`default_nettype none

module bvd_axis_cell
	import bvd_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int NMAX  = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       restart,
	input  wire logic                       adv,
	input  wire logic [$clog2(DEPTH+1)-1:0] dly,
	input  wire logic [$clog2(NMAX+1)-1:0]  len,
	input  wire bvd_tap_t                   tap_in,
	output bvd_tap_t                        tap_out
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (NMAX > 1) ? $clog2(NMAX) : 1;
	localparam int NW = $clog2(NMAX + 1);

	logic [1:0]    mem [DEPTH];
	logic [1:0]    rd_q;
	logic [1:0]    wr_q;
	logic          byp_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] addr_nxt;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] coord_q;
	logic [FW-1:0] dly_m1;
	logic [1:0]    word;
	logic [1:0]    wr_word;
	logic          pass;
	logic          live_out;
	logic          prev_ok;
	logic          next_ok;
	logic          center;

	assign pass     = (dly == '0);
	assign dly_m1   = dly - FW'(1);
	assign addr_nxt = (FW'(addr_q) == dly_m1) ? '0 : addr_q + AW'(1);
	assign word     = byp_q ? wr_q : rd_q;
	assign wr_word  = {word[0], tap_in.occ};
	assign center   = pass ? tap_in.occ : word[0];
	assign live_out = tap_in.live && (fill_q == dly);
	assign prev_ok  = (coord_q != '0);
	assign next_ok  = (NW'(coord_q) != len - NW'(1));

	assign tap_out.live = live_out;
	assign tap_out.occ  = center | (prev_ok & word[1]) | (next_ok & tap_in.occ);

	// ring buffer, read one request ahead
	always_ff @(posedge clk) begin
		if (adv && !pass) begin
			mem[addr_q] <= wr_word;
			rd_q        <= mem[addr_nxt];
			wr_q        <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			coord_q <= '0;
			byp_q   <= 1'b0;
		end else if (restart) begin
			addr_q  <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			coord_q <= '0;
		end else if (adv) begin
			if (!pass) begin
				addr_q <= addr_nxt;
				byp_q  <= (addr_nxt == addr_q);
			end
			if (tap_in.live && fill_q != dly) begin
				fill_q <= fill_q + FW'(1);
			end
			if (live_out) begin
				if (FW'(pos_q) == dly_m1) begin
					pos_q   <= '0;
					coord_q <= (NW'(coord_q) == len - NW'(1)) ? '0 : coord_q + CW'(1);
				end else begin
					pos_q <= pos_q + AW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[src/bvd_out_buf.sv]
//------------------------------------------------------------------------------
// bvd_out_buf: two-entry result buffer
// Holds finished results so the input side keeps moving while the output
// side stalls, until both entries are taken.
//------------------------------------------------------------------------------
`default_nettype none

module bvd_out_buf
	import bvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire bvd_result_t push_data,
	output logic             full,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [0] dilated_bit, [7:1] zero
	output logic             m_axis_tlast   // last_voxel
);

	bvd_result_t slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        pop;
	bvd_result_t head;

	assign full          = (cnt_q == 2'd2);
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign head          = slot_q[rd_ptr_q];
	assign m_axis_tdata  = {7'd0, head.dilated};
	assign m_axis_tlast  = head.last;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/binary_volume_dilation_core.sv]
//------------------------------------------------------------------------------
// binary_volume_dilation_core: streaming 3x3x3 binary dilation
// Raster-order voxel stream in, dilated voxel stream out, built as a chain of
// three one-axis cells (x, y, z) with ring line and plane buffers.
//------------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   tvalid/tready             tdata[0] occupied_bit, tuser[0] func
// m_axis    out  tvalid/tready             tdata[0] dilated_bit, tlast last_voxel
// apb       in   psel/penable/pwrite       size_x @0x0, size_y @0x4, size_z @0x8
//
// One request per cycle; each cell does its work in the cycle of the request.
// A result is released by the request that carries voxel k+sx*sy+sx+1, or by a
// drain request once the volume is in; it is visible the next cycle.
// Reset clears control only; line and plane buffers need no clearing pass.
// s_axis_tready drops only while both entries of the output buffer are taken.
//------------------------------------------------------------------------------
`default_nettype none

module binary_volume_dilation_core
	import bvd_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [0] occupied_bit, [7:1] unused
	input  wire logic [0:0]  s_axis_tuser,  // [0] func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [0] dilated_bit, [7:1] zero
	output logic             m_axis_tlast,  // last_voxel
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int XW  = $clog2(MAX_WIDTH + 1);
	localparam int YW  = $clog2(MAX_HEIGHT + 1);
	localparam int CXW = $clog2(MAX_WIDTH);
	localparam int CYW = $clog2(MAX_HEIGHT);
	localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	logic [6:0]     size_x_q;
	logic [6:0]     size_y_q;
	logic [10:0]    size_z_q;
	logic [XW-1:0]  eff_x;
	logic [YW-1:0]  eff_y;
	logic [ZW-1:0]  eff_z;
	logic [PW-1:0]  plane;
	logic [XW-1:0]  dly_y;
	logic [PW-1:0]  dly_z;

	logic [CXW-1:0] in_x_q;
	logic [CYW-1:0] in_y_q;
	logic [ZCW-1:0] in_z_q;
	logic           done_q;
	logic [CXW-1:0] out_x_q;
	logic [CYW-1:0] out_y_q;
	logic [ZCW-1:0] out_z_q;

	logic           cfg_wr;
	logic           cfg_hit;
	logic           acc;
	logic           voxel;
	logic           adv;
	logic           emit;
	logic           last;
	logic           restart;
	logic           full;
	logic           in_end_x;
	logic           in_end_y;
	logic           in_end_z;
	logic           out_end_x;
	logic           out_end_y;
	logic           out_end_z;
	bvd_tap_t       tap_src;
	bvd_tap_t       tap_x;
	bvd_tap_t       tap_y;
	bvd_tap_t       tap_z;
	bvd_result_t    res;

	// config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_hit = cfg_wr && (paddr[3:2] == REG_SIZE_X || paddr[3:2] == REG_SIZE_Y ||
		paddr[3:2] == REG_SIZE_Z);

	always_comb begin
		case (paddr[3:2])
			REG_SIZE_X: prdata = {25'd0, size_x_q};
			REG_SIZE_Y: prdata = {25'd0, size_y_q};
			REG_SIZE_Z: prdata = {21'd0, size_z_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 7'd64;
			size_y_q <= 7'd64;
			size_z_q <= 11'd64;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SIZE_X: size_x_q <= pwdata[6:0];
				REG_SIZE_Y: size_y_q <= pwdata[6:0];
				REG_SIZE_Z: size_z_q <= pwdata[10:0];
				default:    size_x_q <= size_x_q;
			endcase
		end
	end

	// clamped sizes
	always_comb begin
		if (size_x_q == '0) begin
			eff_x = XW'(1);
		end else if (32'(size_x_q) > MAX_WIDTH) begin
			eff_x = XW'(MAX_WIDTH);
		end else begin
			eff_x = XW'(size_x_q);
		end
		if (size_y_q == '0) begin
			eff_y = YW'(1);
		end else if (32'(size_y_q) > MAX_HEIGHT) begin
			eff_y = YW'(MAX_HEIGHT);
		end else begin
			eff_y = YW'(size_y_q);
		end
		if (size_z_q == '0) begin
			eff_z = ZW'(1);
		end else if (size_z_q > ZW'(Z_MAX)) begin
			eff_z = ZW'(Z_MAX);
		end else begin
			eff_z = size_z_q;
		end
	end

	// cell delays; a flat axis soaks up the slack of thin volumes
	assign plane = PW'(eff_x) * PW'(eff_y);

	always_comb begin
		if (eff_y == YW'(1) && eff_z <= ZW'(2)) begin
			dly_y = eff_x - XW'(1);
		end else begin
			dly_y = eff_x;
		end
		if (eff_z == ZW'(1)) begin
			dly_z = (eff_y == YW'(1)) ? '0 : plane - PW'(eff_x) - PW'(1);
		end else begin
			dly_z = plane;
		end
	end

	// request handling
	assign s_axis_tready = !full;
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign voxel   = (s_axis_tuser[0] == FUNC_VOXEL) && !done_q;
	assign adv     = acc && (voxel || done_q);
	assign emit    = adv && tap_z.live;
	assign restart = cfg_hit || (emit && last);

	assign in_end_x  = (XW'(in_x_q) == eff_x - XW'(1));
	assign in_end_y  = (YW'(in_y_q) == eff_y - YW'(1));
	assign in_end_z  = (ZW'(in_z_q) == eff_z - ZW'(1));
	assign out_end_x = (XW'(out_x_q) == eff_x - XW'(1));
	assign out_end_y = (YW'(out_y_q) == eff_y - YW'(1));
	assign out_end_z = (ZW'(out_z_q) == eff_z - ZW'(1));
	assign last      = out_end_x && out_end_y && out_end_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_x_q  <= '0;
			in_y_q  <= '0;
			in_z_q  <= '0;
			done_q  <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_z_q <= '0;
		end else if (restart) begin
			in_x_q  <= '0;
			in_y_q  <= '0;
			in_z_q  <= '0;
			done_q  <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_z_q <= '0;
		end else begin
			if (adv && voxel) begin
				if (!in_end_x) begin
					in_x_q <= in_x_q + CXW'(1);
				end else begin
					in_x_q <= '0;
					if (!in_end_y) begin
						in_y_q <= in_y_q + CYW'(1);
					end else begin
						in_y_q <= '0;
						if (!in_end_z) begin
							in_z_q <= in_z_q + ZCW'(1);
						end else begin
							in_z_q <= '0;
							done_q <= 1'b1;
						end
					end
				end
			end
			if (emit) begin
				if (!out_end_x) begin
					out_x_q <= out_x_q + CXW'(1);
				end else begin
					out_x_q <= '0;
					if (!out_end_y) begin
						out_y_q <= out_y_q + CYW'(1);
					end else begin
						out_y_q <= '0;
						out_z_q <= out_z_q + ZCW'(1);
					end
				end
			end
		end
	end

	// cell chain x -> y -> z
	assign tap_src.live = 1'b1;
	assign tap_src.occ  = s_axis_tdata[0] & voxel;

	bvd_axis_cell #(
		.DEPTH (2),
		.NMAX  (MAX_WIDTH)
	) u_cell_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.adv     (adv),
		.dly     (2'd1),
		.len     (eff_x),
		.tap_in  (tap_src),
		.tap_out (tap_x)
	);

	bvd_axis_cell #(
		.DEPTH (MAX_WIDTH),
		.NMAX  (MAX_HEIGHT)
	) u_cell_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.adv     (adv),
		.dly     (dly_y),
		.len     (eff_y),
		.tap_in  (tap_x),
		.tap_out (tap_y)
	);

	bvd_axis_cell #(
		.DEPTH (MAX_WIDTH * MAX_HEIGHT),
		.NMAX  (Z_MAX)
	) u_cell_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.adv     (adv),
		.dly     (dly_z),
		.len     (eff_z),
		.tap_in  (tap_y),
		.tap_out (tap_z)
	);

	assign res.dilated = tap_z.occ;
	assign res.last    = last;

	bvd_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (emit),
		.push_data     (res),
		.full          (full),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// checks
	a_done_counters: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (in_x_q == '0 && in_y_q == '0 && in_z_q == '0))
		else $error("input position not parked while volume complete");

	a_drain_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && done_q) |-> tap_z.live)
		else $error("request after complete volume gave no result");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last) |=> (!done_q && out_x_q == '0 && out_y_q == '0 && out_z_q == '0))
		else $error("volume did not restart after last voxel");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !full)
		else $error("result pushed into full output buffer");

endmodule

`default_nettype wire
